// ===== sv/gpc_pkg.sv =====
// gpc_pkg: shared widths, constants and types of the ground point classifier.
// No dependencies.
package gpc_pkg;

  localparam int COORD_BITS    = 20;
  localparam int NORM_BITS     = 16;
  localparam int OFS_BITS      = 18;
  localparam int SENSOR_BITS   = 16;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 18;

  // Range path: point minus sensor offset, squared, summed, then rooted.
  localparam int DIFF_BITS = ((COORD_BITS > SENSOR_BITS) ? COORD_BITS : SENSOR_BITS) + 1;
  localparam int RAD_BITS  = 2 * DIFF_BITS;
  localparam int ROOT_BITS = DIFF_BITS;
  localparam int REM_BITS  = ROOT_BITS + 1;

  // Plane-side delay line: one entry per root cell plus the tolerance stages.
  localparam int SIDE_LEN  = ROOT_BITS + 3;

  // Plane path: S = a*x + b*y + c*z + d*2^14.
  localparam int PROD_BITS    = COORD_BITS + NORM_BITS;
  localparam int OFS_SHIFT    = 14;
  localparam int OFS_EXT_BITS = OFS_BITS + OFS_SHIFT;
  localparam int S_BITS = ((PROD_BITS > OFS_EXT_BITS) ? PROD_BITS : OFS_EXT_BITS) + 2;

  // Distance test: (150*|S|)^2 < T^2 * |n|^2, right side always below 2^57.
  localparam int DIST_SCALE = 150;
  localparam int SCALE_BITS = 8;
  localparam int U_BITS     = S_BITS + SCALE_BITS;
  localparam int U_KEEP     = 29;
  localparam int US_BITS    = 2 * U_KEEP;

  localparam int TOL_BITS   = 13;
  localparam int TSQ_BITS   = 2 * TOL_BITS;
  localparam int NSQ_BITS   = 2 * NORM_BITS;
  localparam int N2_BITS    = 32;
  localparam int RHS_BITS   = TSQ_BITS + N2_BITS;
  localparam int RANGE_NEAR = 1000;
  localparam int RANGE_FAR  = 4000;
  localparam int TOL_MIN    = 1500;
  localparam int TOL_OFS    = 500;
  localparam int TOL_MAX    = 4500;

  localparam int NORMAL_C_RST = 16384;
  localparam int OFFSET_RST   = -1000;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_NORMAL_A     = 3'd0,
    REG_NORMAL_B     = 3'd1,
    REG_NORMAL_C     = 3'd2,
    REG_PLANE_OFFSET = 3'd3,
    REG_SENSOR_X     = 3'd4,
    REG_SENSOR_Y     = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic signed [NORM_BITS-1:0]   normal_a;
    logic signed [NORM_BITS-1:0]   normal_b;
    logic signed [NORM_BITS-1:0]   normal_c;
    logic signed [OFS_BITS-1:0]    plane_offset;
    logic signed [SENSOR_BITS-1:0] sensor_x;
    logic signed [SENSOR_BITS-1:0] sensor_y;
  } cfg_t;

  // One beat of the square-root chain.
  typedef struct packed {
    logic                 vld;
    logic [RAD_BITS-1:0]  rad;
    logic [REM_BITS-1:0]  rem;
    logic [ROOT_BITS-1:0] root;
  } sqrt_beat_t;

endpackage

// ===== sv/ground_point_classifier.sv =====
// ground_point_classifier: marks lidar points as ground against a plane.
// Each point passes the input stages, a chain of one square-root cell per range bit,
// the tolerance stages and an output register before its out_valid beat.
// Throughput: one point per clock; busy is low except during reset.
// Synchronous reset: registers with a reset value return to it, in-flight points are
// dropped, busy and cfg_ready stay high/low respectively until reset is released.
// Depends on gpc_pkg, gpc_cfg, gpc_sqrt_cell, gpc_tol.
module ground_point_classifier import gpc_pkg::*; (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [COORD_BITS-1:0] in_point_x,
  input  logic signed [COORD_BITS-1:0] in_point_y,
  input  logic signed [COORD_BITS-1:0] in_point_z,
  output logic                         out_valid,
  output logic                         out_is_ground,
  output logic                         out_below_plane,
  output logic                         out_near_plane,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [CFG_DATA_BITS-1:0]     cfg_data
);

  typedef struct packed {
    logic               below;
    logic               big;
    logic [US_BITS-1:0] us;
  } side_t;

  cfg_t               cfg;
  logic [N2_BITS-1:0] norm_sq;
  logic               busy_r;
  logic               accept;

  // stage 1
  logic                        v1_r;
  logic signed [DIFF_BITS-1:0] dx1_r, dy1_r;
  logic signed [PROD_BITS-1:0] pa1_r, pb1_r, pc1_r;
  logic signed [DIFF_BITS-1:0] dx_nxt, dy_nxt;
  logic signed [PROD_BITS-1:0] pa_nxt, pb_nxt, pc_nxt;
  // stage 2
  logic                        v2_r;
  logic [RAD_BITS-1:0]         dx2_r, dy2_r;
  logic signed [S_BITS-1:0]    s2_r;
  logic signed [RAD_BITS-1:0]  dx2_nxt, dy2_nxt;
  logic signed [S_BITS-1:0]    s_nxt;
  // stage 3
  logic                        v3_r;
  logic [RAD_BITS-1:0]         rad3_r;
  logic [U_BITS-1:0]           u3_r;
  logic                        below3_r;
  logic [S_BITS-1:0]           abs_s;
  logic [U_BITS-1:0]           u_nxt;
  logic                        below_nxt;
  logic [US_BITS-1:0]          us_nxt;

  side_t      side_r [SIDE_LEN];
  sqrt_beat_t head;
  sqrt_beat_t chain [ROOT_BITS];

  logic                tol_vld;
  logic [RHS_BITS-1:0] rhs;
  side_t               side_end;
  logic                near;

  logic out_valid_r, out_is_ground_r, out_below_plane_r, out_near_plane_r;

  gpc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg),
    .norm_sq   (norm_sq)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy   = busy_r;
  assign accept = start && !busy_r;

  always_comb begin
    dx_nxt = DIFF_BITS'(in_point_x) - DIFF_BITS'(cfg.sensor_x);
    dy_nxt = DIFF_BITS'(in_point_y) - DIFF_BITS'(cfg.sensor_y);
    pa_nxt = cfg.normal_a * in_point_x;
    pb_nxt = cfg.normal_b * in_point_y;
    pc_nxt = cfg.normal_c * in_point_z;

    dx2_nxt = dx1_r * dx1_r;
    dy2_nxt = dy1_r * dy1_r;
    s_nxt   = S_BITS'(pa1_r) + S_BITS'(pb1_r) + S_BITS'(pc1_r)
            + (S_BITS'(cfg.plane_offset) <<< OFS_SHIFT);

    abs_s     = s2_r[S_BITS-1] ? -s2_r : s2_r;
    u_nxt     = abs_s * U_BITS'(DIST_SCALE);
    below_nxt = (!cfg.normal_c[NORM_BITS-1] && (cfg.normal_c != '0) && s2_r[S_BITS-1])
             || (cfg.normal_c[NORM_BITS-1] && !s2_r[S_BITS-1] && (s2_r != '0));

    us_nxt = u3_r[U_KEEP-1:0] * u3_r[U_KEEP-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= accept;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    dx1_r    <= dx_nxt;
    dy1_r    <= dy_nxt;
    pa1_r    <= pa_nxt;
    pb1_r    <= pb_nxt;
    pc1_r    <= pc_nxt;
    dx2_r    <= dx2_nxt;
    dy2_r    <= dy2_nxt;
    s2_r     <= s_nxt;
    rad3_r   <= dx2_r + dy2_r;
    u3_r     <= u_nxt;
    below3_r <= below_nxt;
  end

  // Plane-side results ride alongside the root chain, one entry per stage.
  always_ff @(posedge clk) begin
    side_r[0].below <= below3_r;
    side_r[0].big   <= |u3_r[U_BITS-1:U_KEEP];
    side_r[0].us    <= us_nxt;
    for (int k = 1; k < SIDE_LEN; k++) begin
      side_r[k] <= side_r[k-1];
    end
  end

  assign head.vld  = v3_r;
  assign head.rad  = rad3_r;
  assign head.rem  = '0;
  assign head.root = '0;

  for (genvar g = 0; g < ROOT_BITS; g++) begin : g_cell
    if (g == 0) begin : g_first
      gpc_sqrt_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .beat_in  (head),
        .beat_out (chain[g])
      );
    end else begin : g_next
      gpc_sqrt_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .beat_in  (chain[g-1]),
        .beat_out (chain[g])
      );
    end
  end

  gpc_tol u_tol (
    .clk      (clk),
    .rst_n    (rst_n),
    .vld_in   (chain[ROOT_BITS-1].vld),
    .range_in (chain[ROOT_BITS-1].root),
    .norm_sq  (norm_sq),
    .vld_out  (tol_vld),
    .rhs_out  (rhs)
  );

  // Scaled distance past 2^29 can never beat a right side below 2^57.
  assign side_end = side_r[SIDE_LEN-1];
  assign near     = !side_end.big && (side_end.us < rhs);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= tol_vld;
    end
  end

  always_ff @(posedge clk) begin
    out_is_ground_r   <= side_end.below || near;
    out_below_plane_r <= side_end.below;
    out_near_plane_r  <= near;
  end

  assign out_valid       = out_valid_r;
  assign out_is_ground   = out_is_ground_r;
  assign out_below_plane = out_below_plane_r;
  assign out_near_plane  = out_near_plane_r;

endmodule

// ===== sv/gpc_cfg.sv =====
// gpc_cfg: configuration register file and squared plane normal length.
// Depends on gpc_pkg.
module gpc_cfg import gpc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  output cfg_t                     cfg,
  output logic [N2_BITS-1:0]       norm_sq
);

  cfg_t                 cfg_r;
  logic                 ready_r;
  logic [NSQ_BITS-1:0]  sqa_r, sqb_r, sqc_r;
  logic [N2_BITS-1:0]   norm_sq_r;
  logic signed [NSQ_BITS-1:0] sqa, sqb, sqc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ready_r             <= 1'b0;
      cfg_r.normal_a      <= '0;
      cfg_r.normal_b      <= '0;
      cfg_r.normal_c      <= NORM_BITS'(NORMAL_C_RST);
      cfg_r.plane_offset  <= OFS_BITS'(OFFSET_RST);
      cfg_r.sensor_x      <= '0;
      cfg_r.sensor_y      <= '0;
    end else begin
      ready_r <= 1'b1;
      if (cfg_valid && ready_r) begin
        unique case (cfg_idx_t'(cfg_index))
          REG_NORMAL_A:     cfg_r.normal_a     <= cfg_data[NORM_BITS-1:0];
          REG_NORMAL_B:     cfg_r.normal_b     <= cfg_data[NORM_BITS-1:0];
          REG_NORMAL_C:     cfg_r.normal_c     <= cfg_data[NORM_BITS-1:0];
          REG_PLANE_OFFSET: cfg_r.plane_offset <= cfg_data[OFS_BITS-1:0];
          REG_SENSOR_X:     cfg_r.sensor_x     <= cfg_data[SENSOR_BITS-1:0];
          REG_SENSOR_Y:     cfg_r.sensor_y     <= cfg_data[SENSOR_BITS-1:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    sqa = cfg_r.normal_a * cfg_r.normal_a;
    sqb = cfg_r.normal_b * cfg_r.normal_b;
    sqc = cfg_r.normal_c * cfg_r.normal_c;
  end

  // Squares are non-negative and their sum stays below 2^32.
  always_ff @(posedge clk) begin
    sqa_r     <= sqa;
    sqb_r     <= sqb;
    sqc_r     <= sqc;
    norm_sq_r <= N2_BITS'(sqa_r) + N2_BITS'(sqb_r) + N2_BITS'(sqc_r);
  end

  assign cfg_ready = ready_r;
  assign cfg       = cfg_r;
  assign norm_sq   = norm_sq_r;

endmodule

// ===== sv/gpc_sqrt_cell.sv =====
// gpc_sqrt_cell: one root digit of the integer square root, registered.
// Depends on gpc_pkg.
module gpc_sqrt_cell import gpc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  sqrt_beat_t beat_in,
  output sqrt_beat_t beat_out
);

  sqrt_beat_t           beat_r;
  logic [REM_BITS+1:0]  rem_sh;
  logic [REM_BITS+1:0]  trial;
  logic [REM_BITS+1:0]  diff;
  logic                 take;
  logic [REM_BITS-1:0]  rem_nxt;
  logic [ROOT_BITS-1:0] root_nxt;

  // Bring down the next two radicand bits, try root*4+1.
  always_comb begin
    rem_sh   = {beat_in.rem, beat_in.rad[RAD_BITS-1 -: 2]};
    trial    = (REM_BITS+2)'({beat_in.root, 2'b01});
    diff     = rem_sh - trial;
    take     = (rem_sh >= trial);
    rem_nxt  = take ? diff[REM_BITS-1:0] : rem_sh[REM_BITS-1:0];
    root_nxt = {beat_in.root[ROOT_BITS-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_r.vld <= 1'b0;
    end else begin
      beat_r.vld <= beat_in.vld;
    end
    beat_r.rad  <= beat_in.rad << 2;
    beat_r.rem  <= rem_nxt;
    beat_r.root <= root_nxt;
  end

  assign beat_out = beat_r;

endmodule

// ===== sv/gpc_tol.sv =====
// gpc_tol: range-dependent tolerance and right side of the distance test.
// Depends on gpc_pkg.
module gpc_tol import gpc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 vld_in,
  input  logic [ROOT_BITS-1:0] range_in,
  input  logic [N2_BITS-1:0]   norm_sq,
  output logic                 vld_out,
  output logic [RHS_BITS-1:0]  rhs_out
);

  logic                va_r, vb_r, vc_r;
  logic [TOL_BITS-1:0] tol_r;
  logic [TSQ_BITS-1:0] tsq_r;
  logic [RHS_BITS-1:0] rhs_r;
  logic [TOL_BITS-1:0] tol_nxt;
  logic [TSQ_BITS-1:0] tsq_nxt;
  logic [RHS_BITS-1:0] rhs_nxt;

  // Tolerance in units of mm/150: flat 10 mm, ramp to 30 mm, then flat.
  always_comb begin
    if (range_in <= ROOT_BITS'(RANGE_NEAR)) begin
      tol_nxt = TOL_BITS'(TOL_MIN);
    end else if (range_in < ROOT_BITS'(RANGE_FAR)) begin
      tol_nxt = range_in[TOL_BITS-1:0] + TOL_BITS'(TOL_OFS);
    end else begin
      tol_nxt = TOL_BITS'(TOL_MAX);
    end
    tsq_nxt = tol_r * tol_r;
    rhs_nxt = tsq_r * norm_sq;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else begin
      va_r <= vld_in;
      vb_r <= va_r;
      vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    tol_r <= tol_nxt;
    tsq_r <= tsq_nxt;
    rhs_r <= rhs_nxt;
  end

  assign vld_out = vc_r;
  assign rhs_out = rhs_r;

endmodule

// ===== tb/ground_point_classifier_test.sv =====
// ground_point_classifier_test: self-checking bench for the ground point classifier.
// Runs a table of directed points and register writes, then random plane setups and
// point bursts, and checks every out_valid beat in order. Depends on gpc_pkg.
module ground_point_classifier_test;
  import gpc_pkg::*;

  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_HI = 3'd7;

  localparam int COORD_MIN = -524288;
  localparam int COORD_MAX = 524287;
  localparam int ITEM_TARGET = 1650;

  typedef struct packed {
    logic is_ground;
    logic below_plane;
    logic near_plane;
  } ground_flags_t;

  typedef enum {ROW_POINT, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t                 kind;
    logic [CFG_IDX_BITS-1:0]   idx;
    logic [CFG_DATA_BITS-1:0]  data;
    int                        x;
    int                        y;
    int                        z;
    bit                        typed;
    ground_flags_t             flags;
  } plan_row_t;

  logic                         clk;
  logic                         rst_n = 1'b0;
  logic                         start = 1'b0;
  logic                         busy;
  logic signed [COORD_BITS-1:0] in_point_x = '0;
  logic signed [COORD_BITS-1:0] in_point_y = '0;
  logic signed [COORD_BITS-1:0] in_point_z = '0;
  logic                         out_valid;
  logic                         out_is_ground;
  logic                         out_below_plane;
  logic                         out_near_plane;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [CFG_IDX_BITS-1:0]      cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]     cfg_data = '0;

  ground_flags_t pending_flags[$];
  plan_row_t     plan[$];
  cfg_t          plane_cfg;
  int            fail_count = 0;

  ground_point_classifier uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_point_x      (in_point_x),
    .in_point_y      (in_point_y),
    .in_point_z      (in_point_z),
    .out_valid       (out_valid),
    .out_is_ground   (out_is_ground),
    .out_below_plane (out_below_plane),
    .out_near_plane  (out_near_plane),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic longint unsigned floor_root(longint unsigned v);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int i = 23; i >= 0; i--) begin
      trial = root | (64'd1 << i);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  // Tolerance is carried as 150*tol so the whole test stays in integers.
  function automatic ground_flags_t classify_point(cfg_t k, logic signed [COORD_BITS-1:0] px,
                                                   logic signed [COORD_BITS-1:0] py,
                                                   logic signed [COORD_BITS-1:0] pz);
    longint          na, nb, nc, s, dx, dy;
    longint unsigned r, t, n2, rhs, mag, sq;
    ground_flags_t   f;
    na = $signed(k.normal_a);
    nb = $signed(k.normal_b);
    nc = $signed(k.normal_c);
    s = na * px + nb * py + nc * pz + longint'($signed(k.plane_offset)) * 16384;
    f.below_plane = (nc > 0 && s < 0) || (nc < 0 && s > 0);
    dx = longint'(px) - longint'($signed(k.sensor_x));
    dy = longint'(py) - longint'($signed(k.sensor_y));
    r = floor_root(dx * dx + dy * dy);
    if (r <= 1000) t = 1500;
    else if (r < 4000) t = r + 500;
    else t = 4500;
    n2 = na * na + nb * nb + nc * nc;
    rhs = t * t * n2;
    mag = (s < 0) ? -s : s;
    if (mag >= (64'd1 << 32)) begin
      f.near_plane = 1'b0;
    end else begin
      sq = mag * mag;
      if (sq > 64'hFFFF_FFFF_FFFF_FFFF / 22500) f.near_plane = 1'b0;
      else f.near_plane = (sq * 22500) < rhs;
    end
    f.is_ground = f.below_plane | f.near_plane;
    return f;
  endfunction

  function automatic ground_flags_t flags_of(bit g, bit b, bit n);
    ground_flags_t f;
    f.is_ground = g;
    f.below_plane = b;
    f.near_plane = n;
    return f;
  endfunction

  function automatic void add_point(int x, int y, int z, bit typed = 1'b0,
                                    ground_flags_t flags = '0);
    plan_row_t row;
    row.kind = ROW_POINT;
    row.idx = '0;
    row.data = '0;
    row.x = x;
    row.y = y;
    row.z = z;
    row.typed = typed;
    row.flags = flags;
    plan.insert(plan.size(), row);
  endfunction

  function automatic void add_cfg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
    plan_row_t row;
    row.kind = ROW_CFG;
    row.idx = idx;
    row.data = data;
    row.x = 0;
    row.y = 0;
    row.z = 0;
    row.typed = 1'b0;
    row.flags = '0;
    plan.insert(plan.size(), row);
  endfunction

  function automatic int rand_in(int lo, int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  function automatic int pick_extreme(int lo, int hi);
    case ($urandom_range(0, 3))
      0: return lo;
      1: return hi;
      2: return 0;
      default: return rand_in(lo, hi);
    endcase
  endfunction

  function automatic logic [CFG_DATA_BITS-1:0] word16(int v);
    // upper bits are don't-care for 16-bit registers
    logic [1:0] junk;
    junk = 2'($urandom_range(0, 3));
    return {junk, 16'(v)};
  endfunction

  task automatic feed_point(int x, int y, int z, bit typed, ground_flags_t typed_flags);
    logic signed [COORD_BITS-1:0] px, py, pz;
    px = COORD_BITS'(x);
    py = COORD_BITS'(y);
    pz = COORD_BITS'(z);
    cfg_valid <= 1'b0;
    start <= 1'b1;
    in_point_x <= px;
    in_point_y <= py;
    in_point_z <= pz;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_flags.insert(pending_flags.size(),
                         typed ? typed_flags : classify_point(plane_cfg, px, py, pz));
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_NORMAL_A:     plane_cfg.normal_a = data[NORM_BITS-1:0];
      REG_NORMAL_B:     plane_cfg.normal_b = data[NORM_BITS-1:0];
      REG_NORMAL_C:     plane_cfg.normal_c = data[NORM_BITS-1:0];
      REG_PLANE_OFFSET: plane_cfg.plane_offset = data[OFS_BITS-1:0];
      REG_SENSOR_X:     plane_cfg.sensor_x = data[SENSOR_BITS-1:0];
      REG_SENSOR_Y:     plane_cfg.sensor_y = data[SENSOR_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic wait_drain();
    start <= 1'b0;
    cfg_valid <= 1'b0;
    while (pending_flags.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic random_config();
    int a, b, c, d, sx, sy;
    case ($urandom_range(0, 3))
      0: begin
        // ground-like plane, mostly upright normal
        a = rand_in(-2000, 2000);
        b = rand_in(-2000, 2000);
        c = rand_in(14000, 16384);
        if ($urandom_range(0, 6) == 0) c = -c;
        d = rand_in(-3000, 3000);
        sx = rand_in(-2000, 2000);
        sy = rand_in(-2000, 2000);
      end
      1: begin
        a = $signed(16'($urandom));
        b = $signed(16'($urandom));
        c = $signed(16'($urandom));
        d = $signed(18'($urandom));
        sx = $signed(16'($urandom));
        sy = $signed(16'($urandom));
      end
      2: begin
        a = pick_extreme(-32768, 32767);
        b = pick_extreme(-32768, 32767);
        c = pick_extreme(-32768, 32767);
        d = pick_extreme(-131072, 131071);
        sx = pick_extreme(-32768, 32767);
        sy = pick_extreme(-32768, 32767);
      end
      default: begin
        // nearly vertical plane: tiny or zero c
        a = rand_in(-16384, 16384);
        b = rand_in(-16384, 16384);
        c = rand_in(-4, 4);
        d = rand_in(-5000, 5000);
        sx = rand_in(-500, 500);
        sy = rand_in(-500, 500);
      end
    endcase
    wait_drain();
    write_reg(REG_NORMAL_A, word16(a));
    write_reg(REG_NORMAL_B, word16(b));
    write_reg(REG_NORMAL_C, word16(c));
    write_reg(REG_PLANE_OFFSET, 18'(d));
    write_reg(REG_SENSOR_X, word16(sx));
    write_reg(REG_SENSOR_Y, word16(sy));
  endtask

  always @(posedge clk) begin
    ground_flags_t want;
    if (out_valid) begin
      if (pending_flags.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected result beat: is_ground=%0b below=%0b near=%0b",
                   out_is_ground, out_below_plane, out_near_plane);
      end else begin
        want = pending_flags.pop_front();
        if (out_is_ground !== want.is_ground || out_below_plane !== want.below_plane ||
            out_near_plane !== want.near_plane) begin
          fail_count++;
          if (fail_count <= 10)
            $display("mismatch: want is_ground=%0b below=%0b near=%0b, got %0b %0b %0b",
                     want.is_ground, want.below_plane, want.near_plane,
                     out_is_ground, out_below_plane, out_near_plane);
        end
      end
    end
  end

  initial begin
    int      sent, phase_len, burst_left, x, y, z;
    bit      gappy;
    longint  num, z0;

    plane_cfg.normal_a = '0;
    plane_cfg.normal_b = '0;
    plane_cfg.normal_c = NORM_BITS'(NORMAL_C_RST);
    plane_cfg.plane_offset = OFS_BITS'(OFFSET_RST);
    plane_cfg.sensor_x = '0;
    plane_cfg.sensor_y = '0;

    // reset plane z = 1000 mm, sensor at origin
    add_point(0, 0, 1000, 1, flags_of(1, 0, 1));
    add_point(0, 0, 0, 1, flags_of(1, 1, 0));
    add_point(0, 0, 2000, 1, flags_of(0, 0, 0));
    add_point(0, 0, 1009, 1, flags_of(1, 0, 1));
    add_point(0, 0, 1010, 1, flags_of(0, 0, 0));
    add_point(0, 0, 999, 1, flags_of(1, 1, 1));
    add_point(1000, 0, 1009, 1, flags_of(1, 0, 1));
    add_point(1000, 0, 1010, 1, flags_of(0, 0, 0));
    add_point(4000, 0, 1029, 1, flags_of(1, 0, 1));
    add_point(4000, 0, 1030, 1, flags_of(0, 0, 0));
    add_point(2500, 0, 1019, 1, flags_of(1, 0, 1));
    add_point(0, 2500, 1020, 1, flags_of(0, 0, 0));
    add_point(COORD_MIN, COORD_MIN, COORD_MAX, 1, flags_of(0, 0, 0));
    add_point(COORD_MAX, COORD_MAX, COORD_MIN, 1, flags_of(1, 1, 0));
    // writes to unused indexes must not disturb anything
    add_cfg(REG_SPARE_LO, 18'h3FFFF);
    add_cfg(REG_SPARE_HI, 18'h00000);
    add_point(0, 0, 1000, 1, flags_of(1, 0, 1));
    // all-zero normal: never near, never below
    add_cfg(REG_NORMAL_C, 18'h00000);
    add_point(0, 0, 1000, 1, flags_of(0, 0, 0));
    add_point(0, 0, 0, 1, flags_of(0, 0, 0));
    add_cfg(REG_PLANE_OFFSET, 18'h00000);
    add_point(5, 5, 5, 1, flags_of(0, 0, 0));
    // vertical plane x = 0, c zero so below is never set
    add_cfg(REG_NORMAL_A, 18'h04000);
    add_point(-5, 0, 0, 1, flags_of(1, 0, 1));
    add_point(-100, 0, 0, 1, flags_of(0, 0, 0));
    add_point(0, 7, 9, 1, flags_of(1, 0, 1));
    // normal components past +-1.0 and offset/sensor at their limits
    add_cfg(REG_NORMAL_A, 18'h08000);
    add_cfg(REG_NORMAL_B, 18'h37FFF);
    add_cfg(REG_NORMAL_C, 18'h38000);
    add_cfg(REG_PLANE_OFFSET, 18'h20000);
    add_cfg(REG_SENSOR_X, 18'h18000);
    add_cfg(REG_SENSOR_Y, 18'h07FFF);
    add_point(COORD_MAX, COORD_MIN, COORD_MAX);
    add_point(COORD_MIN, COORD_MAX, COORD_MIN);
    add_point(0, 0, 0);
    add_cfg(REG_PLANE_OFFSET, 18'h1FFFF);
    add_cfg(REG_SENSOR_X, 18'h27FFF);
    add_cfg(REG_SENSOR_Y, 18'h08000);
    add_point(COORD_MAX, COORD_MAX, COORD_MAX);
    add_point(COORD_MIN, COORD_MIN, COORD_MIN);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        if (pending_flags.size() != 0) wait_drain();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        feed_point(plan[i].x, plan[i].y, plan[i].z, plan[i].typed, plan[i].flags);
      end
    end

    sent = 0;
    while (sent < ITEM_TARGET) begin
      random_config();
      phase_len = $urandom_range(40, 160);
      gappy = ($urandom_range(0, 3) != 0);
      burst_left = $urandom_range(1, 24);
      repeat (phase_len) begin
        if ($urandom_range(0, 9) < 7) begin
          x = $signed(plane_cfg.sensor_x) + rand_in(-6000, 6000);
          y = $signed(plane_cfg.sensor_y) + rand_in(-6000, 6000);
        end else begin
          x = rand_in(COORD_MIN, COORD_MAX);
          y = rand_in(COORD_MIN, COORD_MAX);
        end
        if ($urandom_range(0, 19) < 13 && plane_cfg.normal_c != 0) begin
          // land just around the plane so the tolerance edges get hit
          num = longint'($signed(plane_cfg.normal_a)) * x
              + longint'($signed(plane_cfg.normal_b)) * y
              + longint'($signed(plane_cfg.plane_offset)) * 16384;
          z0 = -num / longint'($signed(plane_cfg.normal_c)) + rand_in(-40, 40);
          if (z0 < COORD_MIN) z0 = COORD_MIN;
          if (z0 > COORD_MAX) z0 = COORD_MAX;
          z = int'(z0);
        end else begin
          z = rand_in(COORD_MIN, COORD_MAX);
        end
        feed_point(x, y, z, 1'b0, '0);
        sent++;
        burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          if (gappy) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
          end
        end
      end
    end

    wait_drain();
    repeat (40) @(posedge clk);
    if (fail_count == 0 && pending_flags.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
